// File: sv/fhs_pkg.sv
// Shared types, constants and a helper function for the failover host selector.
package fhs_pkg;

    localparam int MAX_HOSTS     = 16;
    localparam int IDX_W         = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
    localparam int CNT_W         = $clog2(MAX_HOSTS + 1);
    localparam int HC_W          = 5;
    localparam int BACKOFF_W     = 32;
    localparam int RND_W         = 32;
    localparam int ENTRY_W       = 4;
    localparam int TIME_W        = 64;
    localparam int CHOSEN_W      = 4;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 8;

    localparam logic [HC_W-1:0]      HOST_COUNT_RESET = HC_W'(1);
    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET    = BACKOFF_W'(10000000);

    localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF    = CFG_IDX_W'(1);

    localparam logic OP_SELECT   = 1'b0;
    localparam logic OP_MARK_BAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_CMP,
        ST_MARK
    } state_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } mod_status_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [HC_W-1:0] hc);
        logic [HC_W+CNT_W-1:0] wide;
        logic [CNT_W-1:0]      n;
        wide = (HC_W + CNT_W)'(hc);
        if (wide == '0)
            n = CNT_W'(1);
        else if (wide > (HC_W + CNT_W)'(MAX_HOSTS))
            n = CNT_W'(MAX_HOSTS);
        else
            n = CNT_W'(hc);
        return n;
    endfunction

endpackage

// File: sv/fhs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/fhs_mod_unit.sv
// Bit-serial restoring remainder unit: random value modulo the host count.
module fhs_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fhs_pkg::RND_W-1:0]  dividend,
    input  logic [fhs_pkg::CNT_W-1:0]  divisor,
    output fhs_pkg::mod_status_t       status
);

    localparam int STEP_W = $clog2(fhs_pkg::RND_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [fhs_pkg::RND_W-1:0]   dvd_reg, dvd_next;
    logic [fhs_pkg::CNT_W-1:0]   dvs_reg, dvs_next;
    logic [fhs_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [fhs_pkg::CNT_W:0]     shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[fhs_pkg::RND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(fhs_pkg::RND_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[fhs_pkg::RND_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
                rem_next = fhs_pkg::CNT_W'(shifted - {1'b0, dvs_reg});
            else
                rem_next = fhs_pkg::CNT_W'(shifted);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg[fhs_pkg::IDX_W-1:0];

endmodule

// File: sv/failover_host_selector.sv
// Top level of the failover host selector: sequencer, deadline table and result register.
//
// A select transaction first runs the modulo phase (the bit-serial remainder unit, then the
// handover of the remainder), then passes each probed entry through a registered table read
// (ST_RD) and a deadline compare (ST_CMP), for up to n entries, where n is the host count
// in use. The final compare holds for as long as the previous result still waits in the
// output register. A mark-bad transaction passes through ST_MARK and gives no result. The
// block takes one transaction at a time; a finished result waits in an output register
// while the next transaction is accepted. Deadlines are held in a RAM with one valid bit
// per entry, cleared at reset, so no clearing pass is needed after reset.
module failover_host_selector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fhs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fhs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // random_value [31:0], entry_index [35:32], now_time [99:36], zero [103:100]
    input  logic [fhs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op [0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // chosen_index [3:0], zero [7:4]
    output logic [fhs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // all_blocked [0]
    output logic                             m_axis_tuser
);

    localparam int RND_LO   = 0;
    localparam int ENTRY_LO = RND_LO + fhs_pkg::RND_W;
    localparam int TIME_LO  = ENTRY_LO + fhs_pkg::ENTRY_W;

    fhs_pkg::state_t                  state_reg, state_next;
    logic [fhs_pkg::HC_W-1:0]         host_count_reg, host_count_next;
    logic [fhs_pkg::BACKOFF_W-1:0]    backoff_reg, backoff_next;
    logic [fhs_pkg::CNT_W-1:0]        n_reg, n_next;
    logic [fhs_pkg::CNT_W-1:0]        probed_reg, probed_next;
    logic [fhs_pkg::IDX_W-1:0]        pos_reg, pos_next;
    logic [fhs_pkg::ENTRY_W-1:0]      idx_reg, idx_next;
    logic [fhs_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [fhs_pkg::MAX_HOSTS-1:0]    valid_reg, valid_next;
    logic                             out_valid_reg, out_valid_next;
    logic [fhs_pkg::CHOSEN_W-1:0]     out_idx_reg, out_idx_next;
    logic                             out_blk_reg, out_blk_next;

    logic                             in_accept;
    logic                             div_start;
    fhs_pkg::mod_status_t             div_st;
    logic                             ram_we;
    logic [fhs_pkg::TIME_W-1:0]       ram_wdata;
    logic [fhs_pkg::TIME_W-1:0]       ram_rdata;
    logic [fhs_pkg::TIME_W-1:0]       deadline;
    logic [fhs_pkg::TIME_W:0]         sum;
    logic                             slot_free;
    logic [fhs_pkg::CNT_W-1:0]        probed_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == fhs_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    assign sum = {1'b0, now_reg} + {{(fhs_pkg::TIME_W + 1 - fhs_pkg::BACKOFF_W){1'b0}}, backoff_reg};
    assign ram_wdata = sum[fhs_pkg::TIME_W] ? {fhs_pkg::TIME_W{1'b1}} : sum[fhs_pkg::TIME_W-1:0];
    assign deadline  = valid_reg[pos_reg] ? ram_rdata : '0;
    assign probed_inc = probed_reg + fhs_pkg::CNT_W'(1);

    fhs_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_axis_tdata[RND_LO +: fhs_pkg::RND_W]),
        .divisor  (fhs_pkg::eff_count(host_count_reg)),
        .status   (div_st)
    );

    fhs_ram #(
        .WIDTH (fhs_pkg::TIME_W),
        .DEPTH (fhs_pkg::MAX_HOSTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fhs_pkg::IDX_W'(idx_reg)),
        .wdata (ram_wdata),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fhs_pkg::ST_IDLE;
            host_count_reg <= fhs_pkg::HOST_COUNT_RESET;
            backoff_reg    <= fhs_pkg::BACKOFF_RESET;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            n_reg          <= fhs_pkg::CNT_W'(1);
            probed_reg     <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            host_count_reg <= host_count_next;
            backoff_reg    <= backoff_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            probed_reg     <= probed_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        now_reg     <= now_next;
        out_idx_reg <= out_idx_next;
        out_blk_reg <= out_blk_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        host_count_next = host_count_reg;
        backoff_next    = backoff_reg;
        valid_next      = valid_reg;
        n_next          = n_reg;
        probed_next     = probed_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_idx_next    = out_idx_reg;
        out_blk_next    = out_blk_reg;
        div_start       = 1'b0;
        ram_we          = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                fhs_pkg::CFG_HOST_COUNT: host_count_next = cfg_data[fhs_pkg::HC_W-1:0];
                fhs_pkg::CFG_BACKOFF:    backoff_next    = cfg_data[fhs_pkg::BACKOFF_W-1:0];
                default:                 ;
            endcase
        end

        unique case (state_reg)
            fhs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    n_next   = fhs_pkg::eff_count(host_count_reg);
                    idx_next = s_axis_tdata[ENTRY_LO +: fhs_pkg::ENTRY_W];
                    now_next = s_axis_tdata[TIME_LO +: fhs_pkg::TIME_W];
                    if (s_axis_tuser == fhs_pkg::OP_MARK_BAD)
                    begin
                        state_next = fhs_pkg::ST_MARK;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = fhs_pkg::ST_MOD;
                    end
                end
            end
            fhs_pkg::ST_MOD:
            begin
                if (div_st.done)
                begin
                    pos_next    = div_st.rem;
                    probed_next = '0;
                    state_next  = fhs_pkg::ST_RD;
                end
            end
            fhs_pkg::ST_RD:
            begin
                state_next = fhs_pkg::ST_CMP;
            end
            fhs_pkg::ST_CMP:
            begin
                if (!(now_reg < deadline) || probed_inc == n_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = fhs_pkg::CHOSEN_W'(pos_reg);
                        out_blk_next   = (now_reg < deadline);
                        state_next     = fhs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    probed_next = probed_inc;
                    if (fhs_pkg::CNT_W'(pos_reg) + fhs_pkg::CNT_W'(1) == n_reg)
                        pos_next = '0;
                    else
                        pos_next = pos_reg + fhs_pkg::IDX_W'(1);
                    state_next = fhs_pkg::ST_RD;
                end
            end
            fhs_pkg::ST_MARK:
            begin
                if (fhs_pkg::CNT_W'(idx_reg) < n_reg)
                begin
                    ram_we = 1'b1;
                    valid_next[fhs_pkg::IDX_W'(idx_reg)] = 1'b1;
                end
                state_next = fhs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fhs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = fhs_pkg::OUT_DATA_W'(out_idx_reg);
    assign m_axis_tuser  = out_blk_reg;

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fhs_pkg::ST_CMP) |-> (probed_reg < n_reg))
        else $error("probe count reached the host count without finishing");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fhs_pkg::ST_RD || state_reg == fhs_pkg::ST_CMP)
            |-> (fhs_pkg::CNT_W'(pos_reg) < n_reg))
        else $error("probe position beyond the entries in use");

    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == fhs_pkg::ST_MOD))
        else $error("modulo unit finished outside the modulo phase");

    a_result_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == fhs_pkg::ST_CMP))
        else $error("result raised without a finished probe");

endmodule
